// ===== rtl/pbmi_pkg.sv =====
package pbmi_pkg;

  // Defaults for the top level parameters
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 2;
  localparam int DIST_W      = 48;

  // Pipeline depth of the displacement datapath
  localparam int DISP_LAT = 5;

  // Operation codes
  typedef enum logic [0:0] {
    OP_DISP = 1'b0,
    OP_WRAP = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Z = 2'd2;

endpackage

// ===== rtl/pbmi_wrap.sv =====
module pbmi_wrap #(
  parameter int CW = 32,
  parameter int BW = 31
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [CW-1:0]        v,
  input  logic [BW-1:0]        box,
  output logic [CW-1:0]        res
);

  logic [CW-1:0] mag_s [0:CW];
  logic [BW-1:0] rem_s [0:CW];
  logic          neg_s [0:CW];
  logic [CW-1:0] res_next;

  // Take the magnitude and sign of the position
  always_ff @(posedge clk) begin
    if (en) begin
      mag_s[0] <= v[CW-1] ? (~v + 1'b1) : v;
      neg_s[0] <= v[CW-1];
      rem_s[0] <= '0;
    end
  end

  // Restoring remainder, one dividend bit per stage
  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [BW:0] t;
    logic [BW:0] bx;
    logic [BW:0] df;
    assign t  = {rem_s[k], mag_s[k][CW-1-k]};
    assign bx = {1'b0, box};
    assign df = t - bx;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= (t >= bx) ? df[BW-1:0] : t[BW-1:0];
        mag_s[k+1] <= mag_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  // Fold a negative remainder into [0, box); pass through on a zero box
  always_comb begin
    if (box == '0) begin
      res_next = neg_s[CW] ? (~mag_s[CW] + 1'b1) : mag_s[CW];
    end else if (neg_s[CW] && (rem_s[CW] != '0)) begin
      res_next = {{(CW-BW){1'b0}}, box - rem_s[CW]};
    end else begin
      res_next = {{(CW-BW){1'b0}}, rem_s[CW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/pbmi_disp.sv =====
module pbmi_disp #(
  parameter int CW   = 32,
  parameter int BW   = 31,
  parameter int FB   = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [2:0][CW-1:0]            from_a,
  input  logic [2:0][CW-1:0]            to_a,
  input  logic [2:0][BW-1:0]            box,
  output logic [2:0][CW-1:0]            res,
  output logic [pbmi_pkg::DIST_W-1:0]   dsq,
  output logic                          ovf
);
  import pbmi_pkg::*;

  localparam int H  = (CW + 1) / 2;
  localparam int HW = CW - H;
  localparam int SW = 2 * CW + 2;
  localparam int XW = (SW > DIST_W + 1) ? SW : DIST_W + 1;

  logic signed [CW:0]   d1 [0:2];
  logic [2:0][CW-1:0]   res2, res3, res4;
  logic [CW-1:0]        a2 [0:2];
  logic                 ovf2, ovf3, ovf4;
  logic [2*H-1:0]       p0 [0:2];
  logic [CW-1:0]        p1 [0:2];
  logic [2*HW-1:0]      p2 [0:2];
  logic [2*CW-1:0]      sq [0:2];

  logic [2:0][CW-1:0]   res_next;
  logic [CW-1:0]        a_next [0:2];
  logic                 ovf_next;
  logic [XW-1:0]        sum_ext;
  logic [XW-1:0]        shifted;
  logic                 sat;

  // Stage 1: exact difference
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= $signed({to_a[i][CW-1], to_a[i]}) - $signed({from_a[i][CW-1], from_a[i]});
      end
    end
  end

  // Stage 2: half-box correction and clamp
  always_comb begin
    logic signed [CW+1:0] dx;
    logic signed [CW+1:0] d2;
    logic signed [CW+1:0] bx;
    logic signed [CW+1:0] m;
    ovf_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dx = {d1[i][CW], d1[i]};
      d2 = {d1[i], 1'b0};
      bx = $signed({{(CW+2-BW){1'b0}}, box[i]});
      if ((box[i] != '0) && (d2 > bx)) begin
        m = dx - bx;
      end else if ((box[i] != '0) && (d2 < -bx)) begin
        m = dx + bx;
      end else begin
        m = dx;
      end
      if (m > $signed({3'b000, {(CW-1){1'b1}}})) begin
        res_next[i] = {1'b0, {(CW-1){1'b1}}};
        ovf_next    = 1'b1;
      end else if (m < $signed({3'b111, {(CW-1){1'b0}}})) begin
        res_next[i] = {1'b1, {(CW-1){1'b0}}};
        ovf_next    = 1'b1;
      end else begin
        res_next[i] = m[CW-1:0];
      end
      a_next[i] = res_next[i][CW-1] ? (~res_next[i] + 1'b1) : res_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res2 <= res_next;
      ovf2 <= ovf_next;
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a_next[i];
      end
    end
  end

  // Stage 3: partial products of each magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      res3 <= res2;
      ovf3 <= ovf2;
      for (int i = 0; i < 3; i++) begin
        p0[i] <= a2[i][H-1:0] * a2[i][H-1:0];
        p1[i] <= a2[i][CW-1:H] * a2[i][H-1:0];
        p2[i] <= a2[i][CW-1:H] * a2[i][CW-1:H];
      end
    end
  end

  // Stage 4: combine into squares
  always_ff @(posedge clk) begin
    if (en) begin
      res4 <= res3;
      ovf4 <= ovf3;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= {{(2*CW-2*H){1'b0}}, p0[i]}
               + ({{CW{1'b0}}, p1[i]} << (H + 1))
               + ({{(2*CW-2*HW){1'b0}}, p2[i]} << (2 * H));
      end
    end
  end

  // Stage 5: sum, scale and saturate
  always_comb begin
    sum_ext = XW'({2'b00, sq[0]}) + XW'({2'b00, sq[1]}) + XW'({2'b00, sq[2]});
    shifted = sum_ext >> FB;
    sat     = (shifted >> DIST_W) != '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res4;
      ovf <= ovf4;
      dsq <= sat ? {DIST_W{1'b1}} : shifted[DIST_W-1:0];
    end
  end

endmodule

// ===== rtl/periodic_box_minimal_image_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    operation, from_x/y/z, to_x/y/z
// out      output     out_valid / out_ready  res_x/y/z, dist_sq, overflow
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_ready does not stall; the depth is set by the remainder
// pipeline of the wrap path (one dividend bit per stage).
// The displacement path is five stages, delayed to line up with it.
// Reset (synchronous) clears the valid bits and the box lengths to zero.
// A stall on out_ready freezes the whole pipeline; nothing is lost or repeated.
module periodic_box_minimal_image_unit #(
  parameter int COORD_WIDTH = pbmi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pbmi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic signed [COORD_WIDTH-1:0]     from_x,
  input  logic signed [COORD_WIDTH-1:0]     from_y,
  input  logic signed [COORD_WIDTH-1:0]     from_z,
  input  logic signed [COORD_WIDTH-1:0]     to_x,
  input  logic signed [COORD_WIDTH-1:0]     to_y,
  input  logic signed [COORD_WIDTH-1:0]     to_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_WIDTH-1:0]     res_x,
  output logic signed [COORD_WIDTH-1:0]     res_y,
  output logic signed [COORD_WIDTH-1:0]     res_z,
  output logic [pbmi_pkg::DIST_W-1:0]       dist_sq,
  output logic                              overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbmi_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pbmi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pbmi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int BW = (CW - 1 < CFG_DATA_W) ? CW - 1 : CFG_DATA_W;
  localparam int LW = CW + 2;
  localparam int DL = LW - DISP_LAT;

  logic [2:0][BW-1:0]   box;
  logic                 adv;
  logic                 vld [0:LW-1];
  op_t                  opd [0:LW-1];
  logic [2:0][CW-1:0]   from_a, to_a;
  logic [2:0][CW-1:0]   wres;
  logic [2:0][CW-1:0]   dres;
  logic [DIST_W-1:0]    ddist;
  logic                 dovf;
  logic [2:0][CW-1:0]   qres  [0:DL-1];
  logic [DIST_W-1:0]    qdist [0:DL-1];
  logic                 qovf  [0:DL-1];

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  assign from_a = {from_z, from_y, from_x};
  assign to_a   = {to_z, to_y, to_x};

  // Box length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_X: box[0] <= cfg_data[BW-1:0];
        REG_BOX_Y: box[1] <= cfg_data[BW-1:0];
        REG_BOX_Z: box[2] <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and operation travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LW; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LW; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opd[0] <= op_t'(operation);
      for (int k = 1; k < LW; k++) begin
        opd[k] <= opd[k-1];
      end
    end
  end

  // Wrap path, one remainder pipeline per axis
  for (genvar i = 0; i < 3; i++) begin : g_wrap
    pbmi_wrap #(.CW(CW), .BW(BW)) u_wrap (
      .clk (clk),
      .en  (adv),
      .v   (from_a[i]),
      .box (box[i]),
      .res (wres[i])
    );
  end

  // Displacement path
  pbmi_disp #(.CW(CW), .BW(BW), .FB(FRAC_BITS)) u_disp (
    .clk    (clk),
    .en     (adv),
    .from_a (from_a),
    .to_a   (to_a),
    .box    (box),
    .res    (dres),
    .dsq    (ddist),
    .ovf    (dovf)
  );

  // Delay displacement results to the wrap latency
  always_ff @(posedge clk) begin
    if (adv) begin
      qres[0]  <= dres;
      qdist[0] <= ddist;
      qovf[0]  <= dovf;
      for (int k = 1; k < DL; k++) begin
        qres[k]  <= qres[k-1];
        qdist[k] <= qdist[k-1];
        qovf[k]  <= qovf[k-1];
      end
    end
  end

  // Output register: select by operation and hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[LW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (opd[LW-1])
        OP_WRAP: begin
          res_x    <= wres[0];
          res_y    <= wres[1];
          res_z    <= wres[2];
          dist_sq  <= '0;
          overflow <= 1'b0;
        end
        OP_DISP: begin
          res_x    <= qres[DL-1][0];
          res_y    <= qres[DL-1][1];
          res_z    <= qres[DL-1][2];
          dist_sq  <= qdist[DL-1];
          overflow <= qovf[DL-1];
        end
        default: ;
      endcase
    end
  end

endmodule
